### rtl/fibonacci_fast_doubling_mod_defines.svh
// Assertion macros shared by the fast doubling Fibonacci block.
`ifndef FIBONACCI_FAST_DOUBLING_MOD_DEFINES_SVH
`define FIBONACCI_FAST_DOUBLING_MOD_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FDM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdm check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define FDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdm check failed: next-cycle implication");

`endif

### rtl/fdm_pkg.sv
// Package with constants and types of the fast doubling Fibonacci block.
package fdm_pkg;

   localparam int INDEX_BITS = 64;
   localparam int IDX_CNT_W  = $clog2(INDEX_BITS + 1);
   localparam int FIB_W      = 30;

   localparam logic [FIB_W-1:0] MODULUS = 30'd1000000007;
   localparam logic [31:0] MOD_X1 = 32'd1000000007;
   localparam logic [31:0] MOD_X2 = 32'd2000000014;
   localparam logic [31:0] MOD_X3 = 32'd3000000021;
   // floor(2^60 / MODULUS), Barrett reciprocal
   localparam logic [30:0] MU = 31'd1152921496;

   typedef enum logic [1:0] {
      TAG_EVEN  = 2'd0,
      TAG_SQ_LO = 2'd1,
      TAG_SQ_HI = 2'd2
   } tag_type;

   typedef struct packed {
      logic    valid;
      tag_type tag;
   } mm_ctl_type;

   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctl_type;

endpackage

### rtl/fdm_bit_cell.sv
// One cell of the index chain: holds a single index bit.
module fdm_bit_cell (
   input  logic                  clock,
   input  fdm_pkg::chain_ctl_type ctl,
   input  logic                  load_bit,
   input  logic                  shift_in,
   output logic                  bit_out
);
   import fdm_pkg::*;

   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (ctl.load) begin
         bit_in = load_bit;
      end else if (ctl.shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

### rtl/fdm_index_chain.sv
// Row of bit cells that presents the index most significant bit first.
module fdm_index_chain (
   input  logic                           clock,
   input  fdm_pkg::chain_ctl_type          ctl,
   input  logic [fdm_pkg::INDEX_BITS-1:0] load_value,
   output logic                           msb
);
   import fdm_pkg::*;

   logic [INDEX_BITS-1:0] bits;
   logic [INDEX_BITS-1:0] shift_src;

   for (genvar g = 0; g < INDEX_BITS; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign shift_src[g] = 1'b0;
      end else begin : g_rest
         assign shift_src[g] = bits[g-1];
      end
      fdm_bit_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_bit (load_value[g]),
         .shift_in (shift_src[g]),
         .bit_out  (bits[g])
      );
   end

   assign msb = bits[INDEX_BITS-1];

endmodule

### rtl/fdm_mulmod.sv
// Five-stage pipelined multiply modulo 1000000007 with Barrett reduction.
module fdm_mulmod (
   input  logic                      clock,
   input  logic                      reset,
   input  fdm_pkg::mm_ctl_type       req,
   input  logic [fdm_pkg::FIB_W-1:0] op_a,
   input  logic [fdm_pkg::FIB_W-1:0] op_b,
   output fdm_pkg::mm_ctl_type       rsp,
   output logic [fdm_pkg::FIB_W-1:0] product
);
   import fdm_pkg::*;

   mm_ctl_type ctl_ff [0:4];
   mm_ctl_type ctl_in [0:4];

   logic [59:0]      x_ff, x_in;
   logic [61:0]      m_ff, m_in;
   logic [31:0]      xlo2_ff, xlo2_in;
   logic [31:0]      xlo3_ff, xlo3_in;
   logic [31:0]      qp_ff, qp_in;
   logic [60:0]      qp_full;
   logic [31:0]      r_ff, r_in;
   logic [FIB_W-1:0] res_ff, res_in;
   logic [31:0]      r_fix;

   always_comb begin
      ctl_in[0] = req;
      for (int i = 1; i < 5; i++) begin
         ctl_in[i] = ctl_ff[i-1];
      end
   end

   always_comb begin
      x_in    = {30'd0, op_a} * {30'd0, op_b};
      m_in    = {31'd0, x_ff[59:29]} * {31'd0, MU};
      xlo2_in = x_ff[31:0];
      // estimated quotient never exceeds the true one, so the low word suffices
      qp_full = {30'd0, m_ff[61:31]} * {31'd0, MODULUS};
      qp_in   = qp_full[31:0];
      xlo3_in = xlo2_ff;
      r_in    = xlo3_ff - qp_ff;
      // remainder estimate is below four times the modulus
      if (r_ff >= MOD_X3) begin
         r_fix = r_ff - MOD_X3;
      end else if (r_ff >= MOD_X2) begin
         r_fix = r_ff - MOD_X2;
      end else if (r_ff >= MOD_X1) begin
         r_fix = r_ff - MOD_X1;
      end else begin
         r_fix = r_ff;
      end
      res_in = r_fix[FIB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            ctl_ff[i] <= '{valid: 1'b0, tag: TAG_EVEN};
         end
      end else begin
         for (int i = 0; i < 5; i++) begin
            ctl_ff[i] <= ctl_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      m_ff    <= m_in;
      xlo2_ff <= xlo2_in;
      xlo3_ff <= xlo3_in;
      qp_ff   <= qp_in;
      r_ff    <= r_in;
      res_ff  <= res_in;
   end

   assign rsp     = ctl_ff[4];
   assign product = res_ff;

endmodule

### rtl/fibonacci_fast_doubling_mod.sv
// Top level: fast doubling Fibonacci pair modulo 1000000007.
//
// Pulse start while busy is low to hand in req_index; the block then walks the
// index bits from the most significant down, one doubling step per bit, and
// raises rsp_valid for exactly one cycle with F(n) and F(n+1) mod 1000000007 on
// rsp_fib_value and rsp_fib_next. The receiver cannot stall, so sample the
// result in that cycle. For each index bit, three modular products go through
// the five-stage multiply pipeline, followed by the two modular additions.
// busy falls with the strobe, and a new transaction may be started in that
// same cycle.
`include "fibonacci_fast_doubling_mod_defines.svh"

module fibonacci_fast_doubling_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [fdm_pkg::INDEX_BITS-1:0] req_index,
   output logic                           rsp_valid,
   output logic [fdm_pkg::FIB_W-1:0]      rsp_fib_value,
   output logic [fdm_pkg::FIB_W-1:0]      rsp_fib_next
);
   import fdm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PREP  = 6'b000010,
      S_ISSUE = 6'b000100,
      S_WAIT  = 6'b001000,
      S_ODD   = 6'b010000,
      S_SUM   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   tag_type          tag_ff, tag_in;
   logic [IDX_CNT_W-1:0] bits_left_ff, bits_left_in;
   logic [FIB_W-1:0] fk_ff, fk_in;
   logic [FIB_W-1:0] fk1_ff, fk1_in;
   logic [FIB_W-1:0] tm_ff, tm_in;
   logic [FIB_W-1:0] even_ff, even_in;
   logic [FIB_W-1:0] sq_lo_ff, sq_lo_in;
   logic [FIB_W-1:0] sq_hi_ff, sq_hi_in;
   logic [FIB_W-1:0] odd_ff, odd_in;
   logic             rsp_valid_ff, rsp_valid_in;

   chain_ctl_type    chain_ctl;
   logic             cur_bit;
   mm_ctl_type       mm_req;
   mm_ctl_type       mm_rsp;
   logic [FIB_W-1:0] mm_a, mm_b, mm_product;
   logic [31:0]      twice_minus;
   logic [FIB_W-1:0] sum_mod;

   function automatic logic [FIB_W-1:0] add_mod(input logic [FIB_W-1:0] a,
                                                input logic [FIB_W-1:0] b);
      logic [FIB_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MODULUS}) begin
         s = s - {1'b0, MODULUS};
      end
      return s[FIB_W-1:0];
   endfunction

   fdm_index_chain u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .load_value (req_index),
      .msb        (cur_bit)
   );

   fdm_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .req     (mm_req),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .rsp     (mm_rsp),
      .product (mm_product)
   );

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      // 2F(k+1) + P - F(k) lies below three times the modulus
      twice_minus = {1'b0, fk1_ff, 1'b0} + MOD_X1 - {2'b00, fk_ff};
      if (twice_minus >= MOD_X2) begin
         twice_minus = twice_minus - MOD_X2;
      end else if (twice_minus >= MOD_X1) begin
         twice_minus = twice_minus - MOD_X1;
      end
      sum_mod = add_mod(even_ff, odd_ff);
   end

   always_comb begin
      state_in     = state_ff;
      tag_in       = tag_ff;
      bits_left_in = bits_left_ff;
      fk_in        = fk_ff;
      fk1_in       = fk1_ff;
      tm_in        = tm_ff;
      even_in      = even_ff;
      sq_lo_in     = sq_lo_ff;
      sq_hi_in     = sq_hi_ff;
      odd_in       = odd_ff;
      rsp_valid_in = 1'b0;
      chain_ctl    = '{load: 1'b0, shift: 1'b0};
      mm_req       = '{valid: 1'b0, tag: tag_ff};
      mm_a         = fk1_ff;
      mm_b         = fk1_ff;

      // collect products as they leave the pipeline
      if (mm_rsp.valid) begin
         case (mm_rsp.tag)
            TAG_EVEN:  even_in  = mm_product;
            TAG_SQ_LO: sq_lo_in = mm_product;
            TAG_SQ_HI: sq_hi_in = mm_product;
            default:   ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               chain_ctl.load = 1'b1;
               fk_in          = '0;
               fk1_in         = {{(FIB_W-1){1'b0}}, 1'b1};
               bits_left_in   = IDX_CNT_W'(INDEX_BITS);
               state_in       = S_PREP;
            end
         end
         S_PREP: begin
            tm_in    = twice_minus[FIB_W-1:0];
            tag_in   = TAG_EVEN;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            mm_req.valid = 1'b1;
            case (tag_ff)
               TAG_EVEN: begin
                  mm_a   = fk_ff;
                  mm_b   = tm_ff;
                  tag_in = TAG_SQ_LO;
               end
               TAG_SQ_LO: begin
                  mm_a   = fk_ff;
                  mm_b   = fk_ff;
                  tag_in = TAG_SQ_HI;
               end
               default: begin
                  mm_a     = fk1_ff;
                  mm_b     = fk1_ff;
                  state_in = S_WAIT;
               end
            endcase
         end
         S_WAIT: begin
            // the pipeline keeps order, so the last square closes the step
            if (mm_rsp.valid && (mm_rsp.tag == TAG_SQ_HI)) begin
               state_in = S_ODD;
            end
         end
         S_ODD: begin
            odd_in   = add_mod(sq_lo_ff, sq_hi_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            if (cur_bit) begin
               fk_in  = odd_ff;
               fk1_in = sum_mod;
            end else begin
               fk_in  = even_ff;
               fk1_in = odd_ff;
            end
            chain_ctl.shift = 1'b1;
            bits_left_in    = bits_left_ff - 1'b1;
            if (bits_left_ff == {{(IDX_CNT_W-1){1'b0}}, 1'b1}) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_PREP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      bits_left_ff <= bits_left_in;
      fk_ff        <= fk_in;
      fk1_ff       <= fk1_in;
      tm_ff        <= tm_in;
      even_ff      <= even_in;
      sq_lo_ff     <= sq_lo_in;
      sq_hi_ff     <= sq_hi_in;
      odd_ff       <= odd_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fib_value = fk_ff;
   assign rsp_fib_next  = fk1_ff;

   `FDM_ASSERT_NOW(a_rsp_reduced, clock, reset, rsp_valid, (rsp_fib_value < MODULUS) && (rsp_fib_next < MODULUS))
   `FDM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `FDM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `FDM_ASSERT_NOW(a_product_in_wait, clock, reset, mm_rsp.valid, state_ff == S_WAIT)

endmodule

### bench/tb_top.sv
// Self-checking testbench for the fast doubling Fibonacci modulo prime block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fdm_pkg::*;

   localparam longint unsigned FIB_PRIME = 64'd1000000007;
   localparam int DRAIN_CYCLES = 11 * INDEX_BITS + 16;

   typedef struct {
      logic [FIB_W-1:0] fib_value;
      logic [FIB_W-1:0] fib_next;
   } fib_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [INDEX_BITS-1:0] req_index = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [FIB_W-1:0]      rsp_fib_value;
   logic [FIB_W-1:0]      rsp_fib_next;

   fib_pair_type pending_pairs[$];
   int           error_count = 0;
   bit           gaps_enabled = 1'b0;

   fibonacci_fast_doubling_mod dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_fib_value (rsp_fib_value),
      .rsp_fib_next  (rsp_fib_next)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Walk the index bits MSB first, doubling the pair (F(k), F(k+1)) each step.
   function automatic fib_pair_type fib_pair_mod(input logic [INDEX_BITS-1:0] n);
      longint unsigned fk;
      longint unsigned fk1;
      longint unsigned twice_minus;
      longint unsigned even_term;
      longint unsigned odd_term;
      longint unsigned sum;
      fib_pair_type    pair;
      fk = 0;
      fk1 = 1;
      for (int i = INDEX_BITS - 1; i >= 0; i--) begin
         twice_minus = (2 * fk1 + FIB_PRIME - fk) % FIB_PRIME;
         even_term = (fk * twice_minus) % FIB_PRIME;
         odd_term = (fk * fk + fk1 * fk1) % FIB_PRIME;
         if (n[i]) begin
            sum = even_term + odd_term;
            if (sum >= FIB_PRIME) sum -= FIB_PRIME;
            fk = odd_term;
            fk1 = sum;
         end else begin
            fk = even_term;
            fk1 = odd_term;
         end
      end
      pair.fib_value = fk[FIB_W-1:0];
      pair.fib_next = fk1[FIB_W-1:0];
      return pair;
   endfunction

   // Hand one index to the block; record the expected pair once the transaction is taken.
   task automatic send_index(input logic [INDEX_BITS-1:0] idx);
      if (gaps_enabled && $urandom_range(0, 99) < 26) begin
         start <= 1'b0;
         @(posedge clock);
         // hold off past the point where busy drops, by a random amount
         while (busy !== 1'b0 || $urandom_range(0, 99) < 26) @(posedge clock);
      end
      start <= 1'b1;
      req_index <= idx;
      do @(posedge clock); while (busy !== 1'b0);
      pending_pairs.push_back(fib_pair_mod(idx));
   endtask

   function automatic logic [INDEX_BITS-1:0] random_index();
      logic [INDEX_BITS-1:0] value;
      int                    width;
      value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: begin
            width = $urandom_range(1, 12);
            value = value & ((64'd1 << width) - 1);
         end
         1: begin
            width = $urandom_range(1, INDEX_BITS);
            if (width < 64) value = value & ((64'd1 << width) - 1);
            value[width-1] = 1'b1;
         end
         default: ;
      endcase
      return value;
   endfunction

   task automatic test_directed();
      logic [INDEX_BITS-1:0] corner_list[$];
      corner_list = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd10, 64'd90, 64'd1000000006,
                      64'd2000000016, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                      64'h7FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                      64'h5555_5555_5555_5555, 64'h0000_0001_0000_0000,
                      64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'd1 << 31};
      gaps_enabled = 1'b0;
      foreach (corner_list[i]) send_index(corner_list[i]);
   endtask

   task automatic test_back_to_back();
      gaps_enabled = 1'b0;
      repeat (300) send_index(random_index());
   endtask

   task automatic test_random_gaps();
      gaps_enabled = 1'b1;
      repeat (1233) send_index(random_index());
   endtask

   // Compare each strobed result with the oldest expected pair.
   always @(posedge clock) begin
      fib_pair_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_pairs.size() == 0) begin
            $error("unexpected result: fib_value=%0d fib_next=%0d", rsp_fib_value,
                   rsp_fib_next);
            error_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_fib_value !== want.fib_value) begin
               $error("fib_value mismatch: expected %0d, actual %0d", want.fib_value,
                      rsp_fib_value);
               error_count++;
            end
            if (rsp_fib_next !== want.fib_next) begin
               $error("fib_next mismatch: expected %0d, actual %0d", want.fib_next,
                      rsp_fib_next);
               error_count++;
            end
         end
      end
   end

   initial begin
      #100_000_000;
      $display("fibonacci_fast_doubling_mod test failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_to_back();
      test_random_gaps();
      start <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      // catch any stray strobe after the last expected result
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_pairs.size() == 0) begin
         $display("fibonacci_fast_doubling_mod test passed");
      end else begin
         if (pending_pairs.size() != 0) begin
            $error("%0d expected results never arrived", pending_pairs.size());
         end
         $display("fibonacci_fast_doubling_mod test failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/fdm_pkg.sv
rtl/fdm_bit_cell.sv
rtl/fdm_index_chain.sv
rtl/fdm_mulmod.sv
rtl/fibonacci_fast_doubling_mod.sv
bench/tb_top.sv
